// ===== hw/rtl/skx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skx_pkg
// shared constants, types and round functions for the keystream xor core
// ----------------------------------------------------------------------------
package skx_pkg;

  localparam int KEY_BYTES_DEF   = 32;
  localparam int BLOCK_BYTES_DEF = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 64;

  // front-to-back queue entry
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       first;    // byte opens a new keystream block
    logic [4:0] pos;
  } skx_item_t;

  typedef enum logic [1:0] {
    HS_IDLE,
    HS_ROUND,
    HS_FINAL
  } skx_hash_state_t;

  function automatic logic [31:0] skx_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    return k[t];
  endfunction

  function automatic logic [255:0] skx_init_h();
    return {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  endfunction

  function automatic logic [31:0] skx_rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage : skx_pkg
`default_nettype wire

// ===== hw/rtl/skx_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skx_front
// accepts bytes, tracks block position and counter, tags block starts
// ----------------------------------------------------------------------------
module skx_front
  import skx_pkg::*;
#(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  output logic           full,
  input  wire logic [7:0] data_byte,
  input  wire logic      last_byte,
  output logic           q_valid,
  input  wire logic      q_ready,
  output skx_item_t      q_item,
  output logic [31:0]    q_counter
);

  localparam int BL = (BLOCK_BYTES < 1) ? 1 : ((BLOCK_BYTES > 32) ? 32 : BLOCK_BYTES);
  localparam logic [5:0] BL_W = 6'(BL);

  logic [4:0]  pos;
  logic [31:0] counter;
  logic        accept;
  logic [5:0]  pos_inc;

  assign full   = q_valid && !q_ready;
  assign accept = push && !full;
  assign pos_inc = {1'b0, pos} + 6'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      counter <= '0;
      q_valid <= 1'b0;
    end else begin
      if (accept) q_valid <= 1'b1;
      else if (q_ready) q_valid <= 1'b0;
      if (accept) begin
        if (last_byte) begin
          pos     <= '0;
          counter <= '0;
        end else if (pos_inc >= BL_W) begin
          pos     <= '0;
          counter <= counter + 32'd1;
        end else begin
          pos <= pos_inc[4:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_item.data  <= data_byte;
      q_item.last  <= last_byte;
      q_item.first <= (pos == 5'd0);
      q_item.pos   <= pos;
      q_counter    <= counter;
    end
  end

endmodule : skx_front
`default_nettype wire

// ===== hw/rtl/skx_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skx_hash
// one sha-256 round per cycle over key and counter, one padded block
// ----------------------------------------------------------------------------
module skx_hash
  import skx_pkg::*;
#(
  parameter int KEY_BYTES = KEY_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [255:0] key,
  input  wire logic [31:0] counter,
  output logic             busy,
  output logic             done,
  output logic [255:0]     digest
);

  localparam int KL = (KEY_BYTES < 1) ? 1 : ((KEY_BYTES > 32) ? 32 : KEY_BYTES);
  localparam logic [15:0] BITS = 16'((KL + 4) * 8);

  skx_hash_state_t state, state_next;
  logic [5:0]   t;
  logic [31:0]  w [16];
  logic [31:0]  a, b, c, d, e, f, g, h;
  logic [511:0] msg;
  logic [31:0]  wt, s0, s1, w_new, t1, t2;

  always_comb begin
    msg = '0;
    for (int i = 0; i < 32; i++) begin
      if (i < KL) msg[511 - 8*i -: 8] = key[255 - 8*i -: 8];
    end
    msg[511 - 8*KL -: 32] = counter;
    msg[511 - 8*KL - 32 -: 8] = 8'h80;
    msg[15:0] = BITS;
  end

  always_comb begin
    s0 = skx_rotr(w[1], 7) ^ skx_rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = skx_rotr(w[14], 17) ^ skx_rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
    wt = w[0];
    t1 = h + (skx_rotr(e, 6) ^ skx_rotr(e, 11) ^ skx_rotr(e, 25)) +
         ((e & f) ^ (~e & g)) + skx_k(t) + wt;
    t2 = (skx_rotr(a, 2) ^ skx_rotr(a, 13) ^ skx_rotr(a, 22)) +
         ((a & b) ^ (a & c) ^ (b & c));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      HS_IDLE:  if (start) state_next = HS_ROUND;
      HS_ROUND: if (t == 6'd63) state_next = HS_FINAL;
      HS_FINAL: state_next = HS_IDLE;
      default:  state_next = HS_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != HS_IDLE);
    done = 1'b0;
    unique case (state)
      HS_FINAL: done = 1'b1;
      default:  done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= HS_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      HS_IDLE: if (start) begin
        for (int i = 0; i < 16; i++) w[i] <= msg[511 - 32*i -: 32];
        {a, b, c, d, e, f, g, h} <= skx_init_h();
        t <= '0;
      end
      HS_ROUND: begin
        // rolling window: w[0] is the word of round t, next word from window
        for (int i = 0; i < 15; i++) w[i] <= w[i+1];
        w[15] <= w_new;
        {a, b, c, d, e, f, g, h} <= {t1 + t2, a, b, c, d + t1, e, f, g};
        t <= t + 6'd1;
      end
      HS_FINAL: begin
        digest <= {a + 32'h6a09e667, b + 32'hbb67ae85, c + 32'h3c6ef372,
                   d + 32'ha54ff53a, e + 32'h510e527f, f + 32'h9b05688c,
                   g + 32'h1f83d9ab, h + 32'h5be0cd19};
      end
      default: ;
    endcase
  end

endmodule : skx_hash
`default_nettype wire

// ===== hw/rtl/skx_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skx_back
// runs the hash at block starts and xors bytes into the result register
// ----------------------------------------------------------------------------
module skx_back
  import skx_pkg::*;
#(
  parameter int KEY_BYTES = KEY_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  wire skx_item_t   q_item,
  input  wire logic [31:0] q_counter,
  input  wire logic [255:0] key,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic             out_last
);

  logic         h_start, h_busy, h_done;
  logic [255:0] digest;    // held until the next block start
  logic         ks_ok;     // keystream ready for the queued byte
  logic         out_free;

  assign out_free = empty || pop;
  assign h_start  = q_valid && q_item.first && !ks_ok && !h_busy;
  assign q_ready  = q_valid && out_free && (ks_ok || !q_item.first);

  skx_hash #(.KEY_BYTES(KEY_BYTES)) u_hash (
    .clk, .rst, .start(h_start), .key, .counter(q_counter),
    .busy(h_busy), .done(h_done), .digest
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ks_ok <= 1'b0;
      empty <= 1'b1;
    end else begin
      if (h_done) ks_ok <= 1'b1;
      else if (q_ready) ks_ok <= 1'b0;
      if (q_ready) empty <= 1'b0;
      else if (pop) empty <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready) begin
      out_byte <= q_item.data ^ digest[255 - 8*q_item.pos -: 8];
      out_last <= q_item.last;
    end
  end

endmodule : skx_back
`default_nettype wire

// ===== hw/rtl/sha256_counter_keystream_xor_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_counter_keystream_xor_core
// byte stream xor with a sha-256 counter-mode keystream
// ----------------------------------------------------------------------------
//  channel  handshake      payload
//  input    push / full    data_byte, last_byte
//  result   empty / pop    out_byte, out_last
//  config   cfg_we         cfg_idx, cfg_data
//
//  the first byte of a block waits in the queue for one compression (start,
//  64 rounds and final add) before it is taken; other bytes wait only for
//  a free result register
//  reset clears position, counter and handshake state; no clearing pass
//  a stalled result holds the back end; the front keeps one beat queued
// ----------------------------------------------------------------------------
module sha256_counter_keystream_xor_core
  import skx_pkg::*;
#(
  parameter int KEY_BYTES   = KEY_BYTES_DEF,
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  last_byte,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [7:0]                 out_byte,
  output logic                       out_last,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [63:0] key_word [4];
  logic        q_valid, q_ready;
  skx_item_t   q_item;
  logic [31:0] q_counter;

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) key_word[i] <= '0;
    end else if (cfg_we) begin
      key_word[cfg_idx] <= cfg_data;
    end
  end

  skx_front #(.BLOCK_BYTES(BLOCK_BYTES)) u_front (
    .clk, .rst, .push, .full, .data_byte, .last_byte,
    .q_valid, .q_ready, .q_item, .q_counter
  );

  skx_back #(.KEY_BYTES(KEY_BYTES)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item, .q_counter,
    .key({key_word[0], key_word[1], key_word[2], key_word[3]}),
    .empty, .pop, .out_byte, .out_last
  );

endmodule : sha256_counter_keystream_xor_core
`default_nettype wire

// ===== hw/rtl/skx_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skx_checker
// port-level checks on the keystream core
// ----------------------------------------------------------------------------
module skx_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic push,
  input wire logic full,
  input wire logic empty,
  input wire logic pop,
  input wire logic [7:0] out_byte,
  input wire logic out_last
);

  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result not empty after reset");
  a_rst_full: assert property (@(posedge clk) rst |=> !full)
    else $error("full after reset");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_last)))
    else $error("waiting result changed");
  a_no_push_no_result: assert property (@(posedge clk) disable iff (rst)
    (empty && !full && !push) ##1 (empty && !(push && !full)) |=> empty)
    else $error("result without input");

endmodule : skx_checker

bind sha256_counter_keystream_xor_core skx_checker u_skx_checker (
  .clk, .rst, .push, .full, .empty, .pop, .out_byte, .out_last
);
`default_nettype wire

// ===== tb/sha256_counter_keystream_xor_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_counter_keystream_xor_core_test
// drives byte messages through the keystream xor core under several keys,
// with bursty pushes and a stalling receiver, and checks every result beat
// against a sha-256 counter-mode keystream computed here
// ----------------------------------------------------------------------------
module sha256_counter_keystream_xor_core_test;
  import skx_pkg::*;

  localparam int BLOCK_LEN = 16;   // matches the core default
  localparam int SETTLE    = 200;  // more than one compression plus slack
  localparam int LIMIT     = 3000000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 2'd3;

  logic clk;
  logic rst;
  logic push;
  logic full;
  logic [7:0] data_byte;
  logic last_byte;
  logic empty;
  logic pop;
  logic [7:0] out_byte;
  logic out_last;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  sha256_counter_keystream_xor_core u_top (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .data_byte(data_byte), .last_byte(last_byte),
    .empty(empty), .pop(pop), .out_byte(out_byte), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  typedef struct packed {
    logic [7:0] byte_val;
    logic       last;
  } xor_beat_t;

  const logic [31:0] round_const [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  const logic [255:0] start_hash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic [63:0]  key_reg [4];     // copy of the key registers
  logic [31:0]  blk_count;
  logic [4:0]   blk_pos;
  logic [255:0] cur_stream;      // digest of the current block
  xor_beat_t    expected_beats [$];

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one padded block: 32 key bytes, counter, 0x80, zeros, bit length 288
  function automatic logic [255:0] block_digest(logic [31:0] ctr);
    logic [511:0] blk;
    logic [31:0]  w [16];
    logic [31:0]  v [8];
    logic [31:0]  t1, t2, s0, s1;
    blk = {key_reg[0], key_reg[1], key_reg[2], key_reg[3], ctr, 8'h80, 200'd0, 16'h0120};
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
    for (int i = 0; i < 8; i++) v[i] = start_hash[255 - 32 * i -: 32];
    for (int t = 0; t < 64; t++) begin
      if (t >= 16) begin
        s0 = ror32(w[(t - 15) & 15], 7) ^ ror32(w[(t - 15) & 15], 18) ^ (w[(t - 15) & 15] >> 3);
        s1 = ror32(w[(t - 2) & 15], 17) ^ ror32(w[(t - 2) & 15], 19) ^ (w[(t - 2) & 15] >> 10);
        w[t & 15] = w[t & 15] + s0 + w[(t - 7) & 15] + s1;
      end
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_const[t] + w[t & 15];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    return {v[0] + start_hash[255:224], v[1] + start_hash[223:192],
            v[2] + start_hash[191:160], v[3] + start_hash[159:128],
            v[4] + start_hash[127:96],  v[5] + start_hash[95:64],
            v[6] + start_hash[63:32],   v[7] + start_hash[31:0]};
  endfunction

  // advance the keystream state by one accepted byte and queue its result
  function automatic void xor_predict(logic [7:0] d, logic l);
    xor_beat_t b;
    if (blk_pos == 5'd0) cur_stream = block_digest(blk_count);  // key latched here
    b.byte_val = d ^ cur_stream[255 - 8 * blk_pos -: 8];
    b.last = l;
    expected_beats.push_back(b);
    blk_pos = 5'(blk_pos + 5'd1);
    if (blk_pos >= BLOCK_LEN) begin
      blk_pos = '0;
      blk_count = blk_count + 32'd1;
    end
    if (l) begin
      blk_pos = '0;
      blk_count = '0;
    end
  endfunction

  // ---------------------------------------------------------------- receiver
  int errs;
  int stall_mode;
  int stall_left;

  always @(posedge clk) begin
    xor_beat_t e;
    if (!rst && pop && !empty) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected: out_byte %h out_last %b", out_byte, out_last);
        errs++;
      end else begin
        e = expected_beats.pop_front();
        if (out_byte !== e.byte_val) begin
          $error("out_byte: expected %h actual %h", e.byte_val, out_byte);
          errs++;
        end
        if (out_last !== e.last) begin
          $error("out_last: expected %b actual %b", e.last, out_last);
          errs++;
        end
      end
    end
    // stall pattern: modes change now and then, long stalls included
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 150);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: pop <= 1'b1;
      1: pop <= ($urandom_range(0, 1) == 0);
      2: pop <= ($urandom_range(0, 9) == 0);
      default: pop <= ((stall_left % 24) >= 16);
    endcase
  end

  // ---------------------------------------------------------------- watchdog
  int cycles;
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("sha256_counter_keystream_xor_core_test: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sender
  int burst_left;

  task automatic send_beat(logic [7:0] d, logic l);
    int gap;
    push <= 1'b1;
    data_byte <= d;
    last_byte <= l;
    do @(posedge clk); while (full);
    xor_predict(d, l);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // all four key words, back to back, then release the write enable
  task automatic load_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2, logic [63:0] k3);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [63:0] val [4];
    idx = '{REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3};
    val = '{k0, k1, k2, k3};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      key_reg[idx[i]] = val[i];
    end
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) send_beat(8'($urandom_range(0, 255)), i == len - 1);
  endtask

  // directed rows: byte and last flag; results come from the predictor
  typedef struct {
    logic [7:0] d;
    logic       l;
  } stim_row_t;

  stim_row_t plan [$];

  initial begin
    rst = 1'b1;
    push <= 1'b0;
    data_byte <= 8'h00;
    last_byte <= 1'b0;
    pop <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= REG_KEY0;
    cfg_data <= '0;
    errs = 0;
    cycles = 0;
    stall_mode = 0;
    stall_left = 0;
    burst_left = 0;
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    blk_count = 0;
    blk_pos = 0;
    cur_stream = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero key after reset, byte extremes, single-byte messages,
    // then a message that crosses one block edge
    plan.push_back('{8'h00, 1'b1});
    plan.push_back('{8'hff, 1'b1});
    plan.push_back('{8'h00, 1'b0});
    plan.push_back('{8'hff, 1'b0});
    for (int i = 0; i < 15; i++) plan.push_back('{8'(i * 17 + 3), 1'b0});
    plan.push_back('{8'h5a, 1'b1});
    foreach (plan[i]) send_beat(plan[i].d, plan[i].l);
    wait_idle();

    // key change mid-message must not touch the block already under way:
    // keys are written only while idle, so change key between two parts
    load_key('1, '1, '1, '1);
    send_message(1);
    send_message(BLOCK_LEN);
    send_message(2 * BLOCK_LEN + 1);
    wait_idle();

    load_key(64'h8000_0000_0000_0001, '0, '1, 64'h0123_4567_89ab_cdef);
    send_message(BLOCK_LEN + 1);
    wait_idle();

    // random part: several keys, mostly short and mid-length messages
    for (int ph = 0; ph < 6; ph++) begin
      int n;
      int len;
      load_key({$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, {$urandom, $urandom});
      n = 0;
      while (n < 100) begin
        len = $urandom_range(0, 7) == 0 ? $urandom_range(33, 70) : $urandom_range(1, 20);
        send_message(len);
        n += len;
      end
      wait_idle();
    end

    load_key('0, '0, '0, '0);
    send_message(40);
    wait_idle();

    if (errs == 0 && expected_beats.size() == 0) begin
      $display("sha256_counter_keystream_xor_core_test: clean");
    end else begin
      $display("sha256_counter_keystream_xor_core_test: errors");
    end
    $finish;
  end

endmodule
